// ----- rtl/nvbs_pkg.sv -----
// Shared constants for the nearest-value binary search block.
package nvbs_pkg;

  localparam int unsigned NVBS_TABLE_DEPTH = 1024;

  localparam int unsigned DATA_W  = 32;
  localparam int unsigned INDEX_W = 10;
  localparam int unsigned COUNT_W = 11;
  localparam int unsigned APB_AW  = 3;
  localparam int unsigned APB_DW  = 32;

  localparam logic [0:0] CMD_WRITE = 1'b0;
  localparam logic [0:0] CMD_QUERY = 1'b1;

  // Register index as decoded from paddr[2].
  localparam logic REG_ENTRIES_IN_USE = 1'b0;

  localparam logic [COUNT_W-1:0] ENTRIES_RESET = COUNT_W'(1);

endpackage

// ----- rtl/nvbs_if.sv -----
// Valid/ready channel interfaces for query and result transactions.
interface nvbs_in_if;
  import nvbs_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [0:0]                cmd;
  logic [INDEX_W-1:0]        entry_index;
  logic signed [DATA_W-1:0]  value;

  modport source (output valid, cmd, entry_index, value, input ready);
  modport sink   (input valid, cmd, entry_index, value, output ready);
endinterface

interface nvbs_out_if;
  import nvbs_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [DATA_W-1:0]  nearest;

  modport source (output valid, nearest, input ready);
  modport sink   (input valid, nearest, output ready);
endinterface

// ----- rtl/nvbs_cfg.sv -----
// APB register file holding the entries_in_use register.
module nvbs_cfg (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [nvbs_pkg::APB_AW-1:0]  paddr,
  input  logic [nvbs_pkg::APB_DW-1:0]  pwdata,
  output logic [nvbs_pkg::APB_DW-1:0]  prdata,
  output logic                         pready,
  output logic [nvbs_pkg::COUNT_W-1:0] entries_o
);
  import nvbs_pkg::*;

  logic [COUNT_W-1:0] entries_q;
  logic               wr_en;
  logic               sel_entries;

  assign pready      = 1'b1;
  assign sel_entries = (paddr[2] == REG_ENTRIES_IN_USE);
  assign wr_en       = psel && penable && pwrite && pready && sel_entries;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entries_q <= ENTRIES_RESET;
    end else if (wr_en) begin
      entries_q <= pwdata[COUNT_W-1:0];
    end
  end

  assign prdata    = sel_entries ? APB_DW'(entries_q) : '0;
  assign entries_o = entries_q;

endmodule

// ----- rtl/nearest_value_binary_search.sv -----
// Top level: table memory and binary search sequencer for nearest-value queries.
//
//  channel   dir  handshake         payload
//  in_i      in   valid/ready       cmd, entry_index, value
//  out_o     out  valid/ready       nearest
//  apb       in   psel/penable      paddr, pwdata, prdata (entries_in_use at 0x0)
//
// A write transaction stores its value in the table when it is accepted. A query
// issues the first table read and then makes one probe per table read, at most
// ceil(log2(n+1)) probes; the single memory read port sets the pace.
// Reset clears control state only; table contents are undefined until written.
// A finished result waits in the output register and a stalled result holds
// the block until the output register is free.
module nearest_value_binary_search #(
  parameter int unsigned TABLE_DEPTH = nvbs_pkg::NVBS_TABLE_DEPTH
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  nvbs_in_if.sink                      in_i,
  nvbs_out_if.source                   out_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [nvbs_pkg::APB_AW-1:0]  paddr,
  input  logic [nvbs_pkg::APB_DW-1:0]  pwdata,
  output logic [nvbs_pkg::APB_DW-1:0]  prdata,
  output logic                         pready
);
  import nvbs_pkg::*;

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  // Signed search bounds must hold -1 up to TABLE_DEPTH.
  localparam int unsigned PW = $clog2(TABLE_DEPTH + 1) + 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_RESULT
  } state_e;

  state_e                   state_q;
  logic [COUNT_W-1:0]       entries;

  logic signed [DATA_W-1:0] mem [TABLE_DEPTH];
  logic signed [DATA_W-1:0] rdata_q;
  logic [AW-1:0]            raddr;
  logic [AW-1:0]            waddr;
  logic                     we;

  logic signed [PW-1:0]     left_q, right_q, mid_q;
  logic signed [DATA_W-1:0] key_q, best_q;
  logic [DATA_W:0]          bestd_q;
  logic                     first_q;
  logic                     out_valid_q;
  logic signed [DATA_W-1:0] nearest_q;

  logic                     in_fire, out_fire, slot_free, res_load;
  logic [31:0]              ent32, n32;
  logic signed [PW-1:0]     right0, mid0;
  logic signed [DATA_W:0]   diff;
  logic [DATA_W:0]          absd;
  logic                     eq, less, closer, done;
  logic signed [PW-1:0]     nl, nr, nmid;
  logic signed [PW:0]       sum;
  logic signed [DATA_W-1:0] nbest, result;
  logic [DATA_W:0]          nbestd;

  nvbs_cfg u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .entries_o (entries)
  );

  assign in_i.ready    = (state_q == ST_IDLE);
  assign in_fire       = in_i.valid && in_i.ready;
  assign out_fire      = out_valid_q && out_o.ready;
  assign slot_free     = !out_valid_q || out_o.ready;
  assign out_o.valid   = out_valid_q;
  assign out_o.nearest = nearest_q;

  // A new result enters the output register this cycle.
  assign res_load = slot_free
                 && (((state_q == ST_SEARCH) && done) || (state_q == ST_RESULT));

  // Search span: zero entries counts as one, more than the table saturates.
  always_comb begin
    ent32 = 32'(entries);
    if (ent32 == 32'd0) begin
      n32 = 32'd1;
    end else if (ent32 > 32'(TABLE_DEPTH)) begin
      n32 = 32'(TABLE_DEPTH);
    end else begin
      n32 = ent32;
    end
    right0 = $signed(PW'(n32 - 32'd1));
    mid0   = right0 >>> 1;
  end

  // Probe evaluation against the entry read for mid_q.
  always_comb begin
    diff   = $signed({rdata_q[DATA_W-1], rdata_q}) - $signed({key_q[DATA_W-1], key_q});
    absd   = diff[DATA_W] ? $unsigned(-diff) : $unsigned(diff);
    eq     = (rdata_q == key_q);
    less   = (rdata_q < key_q);
    nl     = less ? mid_q + PW'(1) : left_q;
    nr     = less ? right_q : mid_q - PW'(1);
    closer = first_q || (absd < bestd_q);
    nbest  = closer ? rdata_q : best_q;
    nbestd = closer ? absd : bestd_q;
    done   = eq || (nl > nr);
    result = eq ? key_q : nbest;
    sum    = $signed({nl[PW-1], nl}) + $signed({nr[PW-1], nr});
    nmid   = sum[PW:1];
  end

  assign raddr = (state_q == ST_SEARCH) ? nmid[AW-1:0] : mid0[AW-1:0];
  assign waddr = AW'(in_i.entry_index);
  assign we    = in_fire && (in_i.cmd == CMD_WRITE)
              && (32'(in_i.entry_index) < 32'(TABLE_DEPTH));

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= in_i.value;
    end
    rdata_q <= mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      first_q     <= 1'b0;
    end else begin
      if (out_fire && !res_load) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_fire && (in_i.cmd == CMD_QUERY)) begin
            key_q   <= in_i.value;
            left_q  <= '0;
            right_q <= right0;
            mid_q   <= mid0;
            first_q <= 1'b1;
            state_q <= ST_SEARCH;
          end
        end
        ST_SEARCH: begin
          left_q  <= nl;
          right_q <= nr;
          mid_q   <= nmid;
          best_q  <= done ? result : nbest;
          bestd_q <= nbestd;
          first_q <= 1'b0;
          if (done) begin
            if (slot_free) begin
              nearest_q   <= result;
              out_valid_q <= 1'b1;
              state_q     <= ST_IDLE;
            end else begin
              state_q <= ST_RESULT;
            end
          end
        end
        ST_RESULT: begin
          if (slot_free) begin
            nearest_q   <= best_q;
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // A query transaction always starts a search on the next cycle.
  a_query_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (in_i.cmd == CMD_QUERY)) |=> (state_q == ST_SEARCH))
    else $error("query did not start a search");

  // The probed index lies inside the current search bounds.
  a_mid_in_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SEARCH) |-> ((mid_q >= left_q) && (mid_q <= right_q)))
    else $error("probe index outside search bounds");

  // The bounds never leave the table while searching.
  a_bounds_in_table: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SEARCH) |-> ((left_q >= 0) && (right_q < $signed(PW'(TABLE_DEPTH)))))
    else $error("search bounds outside table");

  // A write transaction produces no result.
  a_write_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (in_i.cmd == CMD_WRITE) && !out_valid_q) |=> !out_valid_q)
    else $error("write transaction produced a result");
`endif

endmodule
